>>> rtl/core/mac_learning_forwarder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MAC learning forwarder
// Concurrent assertion helpers, compiled away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MAC_LEARNING_FORWARDER_MACROS_SVH
`define MAC_LEARNING_FORWARDER_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define MLF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define MLF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("implication failed");
`else
`define MLF_ASSERT(lbl, clk, rst_n, prop)
`define MLF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/mlf_pkg.sv
// ----------------------------------------------------------------------------
// MAC learning forwarder package
// Widths, constants, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package mlf_pkg;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned PORT_W  = 4;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned ENTRY_W = MAC_W + PORT_W;

  localparam int unsigned NUM_PORTS         = 16;
  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  // The flood mask only covers ports that exist and fit in the mask.
  localparam int unsigned MASK_PORTS = (NUM_PORTS < MASK_W) ? NUM_PORTS : MASK_W;
  localparam logic [MASK_W-1:0] PORT_LIM = MASK_W'((64'd1 << MASK_PORTS) - 64'd1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESULT
  } mlf_state_e;

  typedef struct packed {
    logic start;     // capture header, restart the scan
    logic scan_rd;   // read the table entry at the scan address
    logic update;    // learn or move the source, form the result
    logic load_out;  // move the result into the output register
  } mlf_cmd_t;

  typedef struct packed {
    logic drop_in;   // offered header carries a port that does not exist
    logic empty;     // no entries learned yet
    logic last_addr; // scan address is the last filled entry
    logic out_free;  // output register can take a result this cycle
  } mlf_status_t;

endpackage

>>> rtl/core/mlf_if.sv
// ----------------------------------------------------------------------------
// MAC learning forwarder channels
// Valid/ready interfaces for frame headers and forwarding results.
// ----------------------------------------------------------------------------
interface mlf_hdr_if;
  import mlf_pkg::*;

  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] ingress_port;
  logic [MAC_W-1:0]  dest_mac;
  logic [MAC_W-1:0]  source_mac;

  modport source (output valid, output ingress_port, output dest_mac,
                  output source_mac, input ready);
  modport sink   (input valid, input ingress_port, input dest_mac,
                  input source_mac, output ready);
endinterface

interface mlf_res_if;
  import mlf_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] egress_mask;
  logic              flooded;
  logic              source_learned;
  logic              source_moved;
  logic              table_full;

  modport source (output valid, output egress_mask, output flooded,
                  output source_learned, output source_moved,
                  output table_full, input ready);
  modport sink   (input valid, input egress_mask, input flooded,
                  input source_learned, input source_moved,
                  input table_full, output ready);
endinterface

>>> rtl/core/mac_learning_forwarder.sv
// ----------------------------------------------------------------------------
// MAC learning forwarder
// Self-learning bridge: learns source addresses, forwards or floods frames.
// ----------------------------------------------------------------------------
// One frame header is taken at a time. The learned table sits in a single
// RAM that is scanned one entry per cycle through its read port, covering
// the entries learned so far (1 to TABLE_ENTRIES). A header that meets an
// empty table skips the scan, and one from a port that does not exist skips
// the scan and the update and leaves an all-zero result. Entries fill in
// order and are never removed, so no clearing pass is needed after reset.
// The result waits in an output register, and the next header is taken
// while it is still pending.
module mac_learning_forwarder #(
  parameter int unsigned TABLE_ENTRIES = mlf_pkg::TABLE_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mlf_hdr_if.sink   hdr_i,
  mlf_res_if.source res_o
);
  import mlf_pkg::*;

  mlf_cmd_t    cmd;
  mlf_status_t status;

  mlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (hdr_i.valid),
    .in_ready_o (hdr_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mlf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .port_i        (hdr_i.ingress_port),
    .dmac_i        (hdr_i.dest_mac),
    .smac_i        (hdr_i.source_mac),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .out_mask_o    (res_o.egress_mask),
    .out_flooded_o (res_o.flooded),
    .out_learned_o (res_o.source_learned),
    .out_moved_o   (res_o.source_moved),
    .out_full_o    (res_o.table_full)
  );

endmodule

>>> rtl/core/mlf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mlf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/mlf_ctrl.sv
// ----------------------------------------------------------------------------
// MAC learning forwarder controller
// Sequences header capture, table scan, update and result hand-off.
// ----------------------------------------------------------------------------
module mlf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mlf_pkg::mlf_status_t status_i,
  output mlf_pkg::mlf_cmd_t    cmd_o
);
  import mlf_pkg::*;

  mlf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          // A frame from a port that does not exist leaves an all-zero result.
          if (status_i.drop_in) begin
            state_d = ST_RESULT;
          end else if (status_i.empty) begin
            state_d = ST_UPDATE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last read returns now and is compared.
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/mlf_datapath.sv
// ----------------------------------------------------------------------------
// MAC learning forwarder datapath
// Address table, scan comparators, learning logic and output register.
// ----------------------------------------------------------------------------
`include "mac_learning_forwarder_macros.svh"

module mlf_datapath #(
  parameter int unsigned TABLE_ENTRIES = mlf_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mlf_pkg::mlf_cmd_t           cmd_i,
  output mlf_pkg::mlf_status_t        status_o,
  input  logic [mlf_pkg::PORT_W-1:0]  port_i,
  input  logic [mlf_pkg::MAC_W-1:0]   dmac_i,
  input  logic [mlf_pkg::MAC_W-1:0]   smac_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [mlf_pkg::MASK_W-1:0]  out_mask_o,
  output logic                        out_flooded_o,
  output logic                        out_learned_o,
  output logic                        out_moved_o,
  output logic                        out_full_o
);
  import mlf_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  // Captured header
  logic [PORT_W-1:0] port_q;
  logic [MAC_W-1:0]  dmac_q;
  logic [MAC_W-1:0]  smac_q;

  // Table state: entries are filled in order and never removed, so the
  // fill count doubles as the valid flags and the next free entry.
  logic [CW-1:0]     count_q;
  logic [MASK_W-1:0] connected_q;

  // Scan state
  logic [AW-1:0]     addr_q;
  logic              rd_valid_q;
  logic [AW-1:0]     rd_idx_q;
  logic              src_hit_q;
  logic [AW-1:0]     src_idx_q;
  logic [PORT_W-1:0] src_port_q;
  logic              dst_hit_q;
  logic [PORT_W-1:0] dst_port_q;

  // Result staging and output register
  logic [MASK_W-1:0] res_mask_q;
  logic              res_flooded_q, res_learned_q, res_moved_q, res_full_q;
  logic              out_valid_q;
  logic [MASK_W-1:0] out_mask_q;
  logic              out_flooded_q, out_learned_q, out_moved_q, out_full_q;

  logic [ENTRY_W-1:0] rdata;
  logic [MAC_W-1:0]   rd_mac;
  logic [PORT_W-1:0]  rd_port;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;

  logic              has_room, move, learn, full;
  logic [MASK_W-1:0] port_bit, conn_d, mask_d;
  logic              flood_d;

  assign rd_mac  = rdata[ENTRY_W-1:PORT_W];
  assign rd_port = rdata[PORT_W-1:0];

  assign has_room = count_q < CW'(TABLE_ENTRIES);
  assign move     = src_hit_q && (src_port_q != port_q);
  assign learn    = !src_hit_q && has_room;
  assign full     = !src_hit_q && !has_room;
  assign port_bit = MASK_W'(1) << port_q;
  assign conn_d   = src_hit_q ? connected_q : (connected_q | port_bit);

  always_comb begin
    flood_d = 1'b0;
    // The destination sees the table after learning: when it equals the
    // source and the source is now held, it resolves to the ingress port.
    if ((dmac_q == smac_q) && !full) begin
      mask_d = port_bit;
    end else if (dst_hit_q) begin
      mask_d = MASK_W'(1) << dst_port_q;
    end else begin
      mask_d  = conn_d & ~port_bit & PORT_LIM;
      flood_d = 1'b1;
    end
  end

  assign ram_we    = cmd_i.update && (move || learn);
  assign ram_waddr = move ? src_idx_q : count_q[AW-1:0];

  mlf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({smac_q, port_q}),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      port_q <= port_i;
      dmac_q <= dmac_i;
      smac_q <= smac_i;
    end
    if (cmd_i.load_out) begin
      out_mask_q    <= res_mask_q;
      out_flooded_q <= res_flooded_q;
      out_learned_q <= res_learned_q;
      out_moved_q   <= res_moved_q;
      out_full_q    <= res_full_q;
    end
    if (cmd_i.scan_rd) begin
      rd_idx_q <= addr_q;
    end
    if (rd_valid_q && (rd_mac == smac_q)) begin
      src_idx_q  <= rd_idx_q;
      src_port_q <= rd_port;
    end
    if (rd_valid_q && (rd_mac == dmac_q)) begin
      dst_port_q <= rd_port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      connected_q   <= '0;
      addr_q        <= '0;
      rd_valid_q    <= 1'b0;
      src_hit_q     <= 1'b0;
      dst_hit_q     <= 1'b0;
      res_mask_q    <= '0;
      res_flooded_q <= 1'b0;
      res_learned_q <= 1'b0;
      res_moved_q   <= 1'b0;
      res_full_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan_rd;
      if (cmd_i.start) begin
        addr_q        <= '0;
        src_hit_q     <= 1'b0;
        dst_hit_q     <= 1'b0;
        res_mask_q    <= '0;
        res_flooded_q <= 1'b0;
        res_learned_q <= 1'b0;
        res_moved_q   <= 1'b0;
        res_full_q    <= 1'b0;
      end
      if (cmd_i.scan_rd) begin
        addr_q <= addr_q + AW'(1);
      end
      if (rd_valid_q && (rd_mac == smac_q)) begin
        src_hit_q <= 1'b1;
      end
      if (rd_valid_q && (rd_mac == dmac_q)) begin
        dst_hit_q <= 1'b1;
      end
      if (cmd_i.update) begin
        connected_q   <= conn_d;
        res_mask_q    <= mask_d;
        res_flooded_q <= flood_d;
        res_learned_q <= learn;
        res_moved_q   <= move;
        res_full_q    <= full;
        if (learn) begin
          count_q <= count_q + CW'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.drop_in   = 32'(port_i) >= NUM_PORTS;
  assign status_o.empty     = count_q == '0;
  assign status_o.last_addr = CW'(addr_q) == (count_q - CW'(1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_mask_o    = out_mask_q;
  assign out_flooded_o = out_flooded_q;
  assign out_learned_o = out_learned_q;
  assign out_moved_o   = out_moved_q;
  assign out_full_o    = out_full_q;

  `MLF_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(TABLE_ENTRIES))
  `MLF_ASSERT_IMPL(a_read_in_fill, clk_i, rst_ni, rd_valid_q, CW'(rd_idx_q) < count_q)
  `MLF_ASSERT_IMPL(a_learn_counts, clk_i, rst_ni, cmd_i.update && learn, ##1 (count_q == $past(count_q) + CW'(1)))
  `MLF_ASSERT_IMPL(a_flags_excl, clk_i, rst_ni, out_valid_q, ($countones({out_learned_q, out_moved_q, out_full_q}) <= 1))

endmodule

>>> sim/mac_learning_forwarder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MAC learning forwarder testbench
// Sends frame headers through the header channel and predicts each
// forwarding result with a behavioural bridge table of its own. Results are
// checked field by field, in order, as they leave the result channel. The run
// covers directed corner cases, random traffic over a partly filled table, a
// table fill to capacity and random traffic against a full table. Each random
// part runs with no idling, an idle sender, a stalling receiver and both.
// ----------------------------------------------------------------------------
module mac_learning_forwarder_tb;
  import mlf_pkg::*;

  localparam int unsigned TBL_DEPTH    = TABLE_ENTRIES_DEF;
  localparam int unsigned DRAIN_CYCLES = TBL_DEPTH + 16;

  typedef struct packed {
    logic [MASK_W-1:0] egress_mask;
    logic              flooded;
    logic              source_learned;
    logic              source_moved;
    logic              table_full;
  } fwd_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mlf_hdr_if hdr ();
  mlf_res_if res ();

  mac_learning_forwarder #(
    .TABLE_ENTRIES(TBL_DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hdr_i  (hdr),
    .res_o  (res)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Behavioural copy of the bridge table.
  logic [MAC_W-1:0]  bridge_mac   [TBL_DEPTH];
  logic [PORT_W-1:0] bridge_port  [TBL_DEPTH];
  logic              bridge_valid [TBL_DEPTH];
  logic [MASK_W-1:0] bridge_connected;
  int unsigned       bridge_fill;

  fwd_result_t fwd_expect_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;
  int unsigned n_headers;
  int unsigned n_results;
  int unsigned n_learned;
  int unsigned n_moved;
  int unsigned n_flooded;
  int unsigned n_full;

  function automatic int bridge_lookup(logic [MAC_W-1:0] mac);
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (bridge_valid[i] && bridge_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  // Learns or moves the source, then decides where the frame goes.
  function automatic fwd_result_t forward_decision(logic [PORT_W-1:0] port,
                                                   logic [MAC_W-1:0] dmac,
                                                   logic [MAC_W-1:0] smac);
    fwd_result_t r;
    int          idx;
    int          slot;
    r = '0;
    if (int'(port) >= int'(NUM_PORTS)) return r;

    idx = bridge_lookup(smac);
    if (idx < 0) begin
      // A station was seen on this port even if it cannot be stored.
      bridge_connected[port] = 1'b1;
      slot = -1;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        if (slot < 0 && !bridge_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        bridge_mac[slot]   = smac;
        bridge_port[slot]  = port;
        bridge_valid[slot] = 1'b1;
        bridge_fill++;
        r.source_learned = 1'b1;
      end else begin
        r.table_full = 1'b1;
      end
    end else if (bridge_port[idx] != port) begin
      bridge_port[idx] = port;
      r.source_moved   = 1'b1;
    end

    idx = bridge_lookup(dmac);
    if (idx < 0) begin
      r.egress_mask = bridge_connected & ~(MASK_W'(1) << port) & PORT_LIM;
      r.flooded     = 1'b1;
    end else begin
      r.egress_mask = MASK_W'(1) << bridge_port[idx];
    end
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[MAC_W-1:0];
  endfunction

  // Picks a learned address with the given likelihood, else a fresh one.
  function automatic logic [MAC_W-1:0] pick_mac(int unsigned known_pct);
    if (bridge_fill > 0 && $urandom_range(0, 99) < known_pct)
      return bridge_mac[$urandom_range(0, bridge_fill - 1)];
    return random_mac();
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_header(logic [PORT_W-1:0] port, logic [MAC_W-1:0] dmac,
                             logic [MAC_W-1:0] smac);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      hdr.valid <= 1'b0;
      @(negedge clk_i);
    end
    hdr.valid        <= 1'b1;
    hdr.ingress_port <= port;
    hdr.dest_mac     <= dmac;
    hdr.source_mac   <= smac;
    do @(posedge clk_i); while (!hdr.ready);
    fwd_expect_q.push_back(forward_decision(port, dmac, smac));
    n_headers++;
    @(negedge clk_i);
  endtask

  function automatic void check_field(string name, logic [MASK_W-1:0] exp_v,
                                      logic [MASK_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(negedge clk_i) begin
    res.ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    fwd_result_t exp_r;
    if (rst_ni && res.valid && res.ready) begin
      if (fwd_expect_q.size() == 0) begin
        $error("result transfer with no header outstanding");
        fail_count++;
      end else begin
        exp_r = fwd_expect_q.pop_front();
        check_field("egress_mask", exp_r.egress_mask, res.egress_mask);
        check_field("flooded", MASK_W'(exp_r.flooded), MASK_W'(res.flooded));
        check_field("source_learned", MASK_W'(exp_r.source_learned),
                    MASK_W'(res.source_learned));
        check_field("source_moved", MASK_W'(exp_r.source_moved),
                    MASK_W'(res.source_moved));
        check_field("table_full", MASK_W'(exp_r.table_full), MASK_W'(res.table_full));
        n_results++;
        n_learned += exp_r.source_learned;
        n_moved   += exp_r.source_moved;
        n_flooded += exp_r.flooded;
        n_full    += exp_r.table_full;
      end
    end
  end

  task automatic random_traffic(int n, int unsigned send_pct, int unsigned recv_pct,
                                int unsigned fresh_src_pct);
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  dmac;
    logic [MAC_W-1:0]  smac;
    int                idx;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int k = 0; k < n; k++) begin
      smac = pick_mac(100 - fresh_src_pct);
      port = PORT_W'($urandom_range(0, 15));
      // Most known stations stay put, so hits without a move are common.
      idx = bridge_lookup(smac);
      if (idx >= 0 && $urandom_range(0, 99) < 60) port = bridge_port[idx];
      case ($urandom_range(0, 19))
        0:          dmac = '0;
        1:          dmac = '1;
        2, 3, 4, 5: dmac = random_mac();
        default:    dmac = pick_mac(100);
      endcase
      send_header(port, dmac, smac);
    end
  endtask

  task automatic test_directed_cases();
    logic [MAC_W-1:0] mac_a;
    logic [MAC_W-1:0] mac_b;
    logic [MAC_W-1:0] mac_c;
    mac_a = 48'h0200_0000_0001;
    mac_b = 48'h0200_0000_0002;
    mac_c = 48'h0200_0000_00c3;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Destination zero is unknown although the cleared table holds zeros;
    // the flood mask is empty since only the ingress port is connected.
    send_header(4'd3, '0, mac_a);
    send_header(4'd5, mac_a, mac_b);
    // A hit on the ingress port itself still gives that port.
    send_header(4'd3, mac_a, mac_a);
    send_header(4'd0, '1, '0);
    send_header(4'd15, '0, '1);
    send_header(4'd15, mac_c, '1);
    // Moves leave the connected ports as they were.
    send_header(4'd9, mac_b, mac_a);
    send_header(4'd1, mac_c, mac_a);
    send_header(4'd1, mac_a, mac_a);
    send_header(4'd12, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
    send_header(4'd6, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    send_header(4'd10, '1, '0);
    send_header(4'd2, '0, mac_c);
  endtask

  task automatic test_random_partial_table();
    random_traffic(150, 0, 0, 4);
    random_traffic(150, 79, 0, 4);
    random_traffic(150, 0, 79, 4);
    random_traffic(150, 15, 15, 4);
  endtask

  task automatic test_table_fill();
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    while (bridge_fill < TBL_DEPTH) begin
      send_header(PORT_W'($urandom_range(0, 15)), bridge_mac[bridge_fill - 1],
                  random_mac());
    end
    // New sources are now refused, but their ports still become connected.
    for (int k = 0; k < 8; k++) begin
      send_header(PORT_W'($urandom_range(0, 15)), bridge_mac[TBL_DEPTH - 1],
                  random_mac());
    end
  endtask

  task automatic test_random_full_table();
    random_traffic(200, 0, 0, 15);
    random_traffic(200, 79, 0, 15);
    random_traffic(200, 0, 79, 15);
    random_traffic(200, 15, 15, 15);
  endtask

  initial begin
    rst_ni           = 1'b0;
    hdr.valid        = 1'b0;
    hdr.ingress_port = '0;
    hdr.dest_mac     = '0;
    hdr.source_mac   = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    fail_count       = 0;
    n_headers        = 0;
    n_results        = 0;
    n_learned        = 0;
    n_moved          = 0;
    n_flooded        = 0;
    n_full           = 0;
    bridge_connected = '0;
    bridge_fill      = 0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      bridge_mac[i]   = '0;
      bridge_port[i]  = '0;
      bridge_valid[i] = 1'b0;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_partial_table();
    test_table_fill();
    test_random_full_table();

    hdr.valid      <= 1'b0;
    recv_stall_pct = 0;
    while (fwd_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results from %0d headers over a partial and a full table.",
             n_results, n_headers);
    $display("Seen: %0d learned, %0d moved, %0d flooded, %0d refused on a full table.",
             n_learned, n_moved, n_flooded, n_full);
    if (fail_count == 0) begin
      $display("mac_learning_forwarder regression: pass");
    end else begin
      $display("mac_learning_forwarder regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("mac_learning_forwarder regression: fail");
    $finish;
  end

endmodule

>>> mac_learning_forwarder.f
+incdir+rtl/core
rtl/core/mlf_pkg.sv
rtl/core/mlf_if.sv
rtl/core/mlf_ram.sv
rtl/core/mlf_ctrl.sv
rtl/core/mlf_datapath.sv
rtl/core/mac_learning_forwarder.sv
sim/mac_learning_forwarder_tb.sv
